[hw/rtl/pmul_pkg.sv]
// Shared types and constants for the sparse polynomial multiplier.
package pmul_pkg;

  // Fixed field widths of the stream words.
  localparam int unsigned OP_W      = 3;
  localparam int unsigned COEF_W    = 16;
  localparam int unsigned EXP_W     = 8;
  localparam int unsigned PCOEF_W   = 32;
  localparam int unsigned PEXP_W    = 9;
  localparam int unsigned S_TDATA_W = 24;
  localparam int unsigned M_TDATA_W = 48;

  // Operation codes carried in the input tuser.
  typedef enum logic [OP_W-1:0] {
    OP_CLEAR       = 3'd0,
    OP_LOAD_FIRST  = 3'd1,
    OP_LOAD_SECOND = 3'd2,
    OP_COMPUTE     = 3'd3,
    OP_READ        = 3'd4
  } op_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic clr_regs;     // zero term counts and the overflow flag
    logic wipe_start;   // restart the result store sweep, no terms pending
    logic wipe_step;    // clear one result entry
    logic load_first;   // store a term of the first polynomial
    logic load_second;  // store a term of the second polynomial
    logic pair_start;   // point at the first product pair
    logic mul_capture;  // register product and exponent sum
    logic acc_read;     // read the result entry of the exponent sum
    logic acc_write;    // write back the accumulated sum
    logic pair_next;    // advance to the next product pair
    logic pos_top;      // point the read position above the store
    logic pos_read;     // read the entry below the read position
    logic pos_dec;      // step the read position down
    logic hit_take;     // take the found term
    logic scan_read;    // read the entry below the scan pointer
    logic scan_dec;     // step the scan pointer down
    logic hit_empty;    // nothing left to read
    logic set_last;     // found term is the lowest
    logic clr_last;     // a lower term exists
    logic emit;         // load the output register
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic wipe_last;      // sweep is at the top entry
    logic terms_present;  // both polynomials hold terms
    logic pair_last;      // current pair is the final one
    logic pos_zero;       // no entries below the read position
    logic scan_zero;      // no entries below the scan pointer
    logic rd_present;     // registered result entry is occupied
    logic out_free;       // output register can take a word
  } sts_t;

endpackage

[hw/rtl/pmul_ctrl.sv]
// Controller state machine of the sparse polynomial multiplier.
module pmul_ctrl import pmul_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  input  logic [OP_W-1:0] opcode_i,
  output logic            in_ready_o,
  input  sts_t            sts_i,
  output cmd_t            cmd_o
);

  typedef enum logic [11:0] {
    S_WIPE     = 12'b0000_0000_0001,
    S_WIPE_CMP = 12'b0000_0000_0010,
    S_IDLE     = 12'b0000_0000_0100,
    S_MRD      = 12'b0000_0000_1000,
    S_MMUL     = 12'b0000_0001_0000,
    S_MRES     = 12'b0000_0010_0000,
    S_MACC     = 12'b0000_0100_0000,
    S_FIND1    = 12'b0000_1000_0000,
    S_CHK1     = 12'b0001_0000_0000,
    S_FIND2    = 12'b0010_0000_0000,
    S_CHK2     = 12'b0100_0000_0000,
    S_EMIT     = 12'b1000_0000_0000
  } state_e;

  state_e state_q, state_d;
  logic   accept;

  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i & in_ready_o;

  // Next state and command decode.
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_WIPE: begin
        cmd_o.wipe_step = 1'b1;
        if (sts_i.wipe_last) begin
          state_d = S_IDLE;
        end
      end
      S_WIPE_CMP: begin
        cmd_o.wipe_step = 1'b1;
        if (sts_i.wipe_last) begin
          if (sts_i.terms_present) begin
            cmd_o.pair_start = 1'b1;
            state_d          = S_MRD;
          end else begin
            cmd_o.pos_top = 1'b1;
            state_d       = S_IDLE;
          end
        end
      end
      S_IDLE: begin
        if (accept) begin
          unique case (op_e'(opcode_i))
            OP_CLEAR: begin
              cmd_o.clr_regs   = 1'b1;
              cmd_o.wipe_start = 1'b1;
              state_d          = S_WIPE;
            end
            OP_LOAD_FIRST:  cmd_o.load_first  = 1'b1;
            OP_LOAD_SECOND: cmd_o.load_second = 1'b1;
            OP_COMPUTE: begin
              cmd_o.wipe_start = 1'b1;
              state_d          = S_WIPE_CMP;
            end
            OP_READ: state_d = S_FIND1;
            default: ;
          endcase
        end
      end
      // Term data becomes valid in the cycle after the indices settle.
      S_MRD: state_d = S_MMUL;
      S_MMUL: begin
        cmd_o.mul_capture = 1'b1;
        state_d           = S_MRES;
      end
      S_MRES: begin
        cmd_o.acc_read = 1'b1;
        state_d        = S_MACC;
      end
      S_MACC: begin
        cmd_o.acc_write = 1'b1;
        cmd_o.pair_next = 1'b1;
        if (sts_i.pair_last) begin
          cmd_o.pos_top = 1'b1;
          state_d       = S_IDLE;
        end else begin
          state_d = S_MRD;
        end
      end
      // Search downward for the next occupied exponent.
      S_FIND1: begin
        if (sts_i.pos_zero) begin
          cmd_o.hit_empty = 1'b1;
          state_d         = S_EMIT;
        end else begin
          cmd_o.pos_read = 1'b1;
          state_d        = S_CHK1;
        end
      end
      S_CHK1: begin
        if (sts_i.rd_present) begin
          cmd_o.hit_take = 1'b1;
          state_d        = S_FIND2;
        end else begin
          cmd_o.pos_dec = 1'b1;
          state_d       = S_FIND1;
        end
      end
      // Look further down to tell whether the found term is the last.
      S_FIND2: begin
        if (sts_i.scan_zero) begin
          cmd_o.set_last = 1'b1;
          state_d        = S_EMIT;
        end else begin
          cmd_o.scan_read = 1'b1;
          state_d         = S_CHK2;
        end
      end
      S_CHK2: begin
        if (sts_i.rd_present) begin
          cmd_o.clr_last = 1'b1;
          state_d        = S_EMIT;
        end else begin
          cmd_o.scan_dec = 1'b1;
          state_d        = S_FIND2;
        end
      end
      S_EMIT: begin
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // State register; reset starts with a sweep of the result store.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_WIPE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

[hw/rtl/pmul_dpath.sv]
// Datapath of the sparse polynomial multiplier: term stores, result store, output word.
module pmul_dpath import pmul_pkg::*; #(
  parameter int MAX_TERMS    = 16,
  parameter int MAX_EXPONENT = 255
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  cmd_t                     cmd_i,
  input  logic signed [COEF_W-1:0] coefficient_i,
  input  logic [EXP_W-1:0]         exponent_i,
  input  logic                     out_ready_i,
  output sts_t                     sts_o,
  output logic                     out_valid_o,
  output logic [PCOEF_W-1:0]       product_coefficient_o,
  output logic [PEXP_W-1:0]        product_exponent_o,
  output logic                     last_term_o,
  output logic                     empty_res_o,
  output logic                     overflow_o
);

  localparam int RES_DEPTH = 2 * MAX_EXPONENT + 1;
  localparam int RA_W      = $clog2(RES_DEPTH);
  localparam int RP_W      = $clog2(RES_DEPTH + 1);
  localparam int IDX_W     = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
  localparam int CNT_W     = $clog2(MAX_TERMS + 1);

  // Term stores.
  logic signed [COEF_W-1:0] fc_mem [MAX_TERMS];
  logic [EXP_W-1:0]         fe_mem [MAX_TERMS];
  logic signed [COEF_W-1:0] sc_mem [MAX_TERMS];
  logic [EXP_W-1:0]         se_mem [MAX_TERMS];
  logic signed [COEF_W-1:0] fc_rd_q, sc_rd_q;
  logic [EXP_W-1:0]         fe_rd_q, se_rd_q;

  // Result store: occupied bit over the running sum.
  logic [PCOEF_W:0]         res_mem [RES_DEPTH];
  logic [PCOEF_W:0]         res_rd_q;

  logic [CNT_W-1:0]         first_cnt_q, second_cnt_q;
  logic [IDX_W-1:0]         i_q, j_q;
  logic                     overflow_q;
  logic [RA_W-1:0]          sweep_q;
  logic [RP_W-1:0]          pos_q;
  logic [RA_W-1:0]          scan_q;
  logic signed [PCOEF_W-1:0] prod_q;
  logic [RA_W-1:0]          esum_q;
  logic [PCOEF_W-1:0]       hit_sum_q;
  logic [PEXP_W-1:0]        hit_exp_q;
  logic                     hit_last_q;
  logic                     hit_empty_q;
  logic                     out_valid_q;

  logic                     exp_ok;
  logic                     first_full, second_full;
  logic                     i_last, j_last;
  logic                     res_we, res_re;
  logic [RA_W-1:0]          res_waddr, res_raddr;
  logic [PCOEF_W:0]         res_wdata;

  assign exp_ok      = (32'(exponent_i) <= MAX_EXPONENT);
  assign first_full  = (first_cnt_q == CNT_W'(MAX_TERMS));
  assign second_full = (second_cnt_q == CNT_W'(MAX_TERMS));
  assign i_last      = (CNT_W'(i_q) == first_cnt_q - CNT_W'(1));
  assign j_last      = (CNT_W'(j_q) == second_cnt_q - CNT_W'(1));

  // Term store writes and registered reads at the pair indices.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_first && exp_ok && !first_full) begin
      fc_mem[first_cnt_q[IDX_W-1:0]] <= coefficient_i;
      fe_mem[first_cnt_q[IDX_W-1:0]] <= exponent_i;
    end
    fc_rd_q <= fc_mem[i_q];
    fe_rd_q <= fe_mem[i_q];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_second && exp_ok && !second_full) begin
      sc_mem[second_cnt_q[IDX_W-1:0]] <= coefficient_i;
      se_mem[second_cnt_q[IDX_W-1:0]] <= exponent_i;
    end
    sc_rd_q <= sc_mem[j_q];
    se_rd_q <= se_mem[j_q];
  end

  // Result store port selection: sweep or accumulate on write, three read sources.
  assign res_we    = cmd_i.wipe_step | cmd_i.acc_write;
  assign res_waddr = cmd_i.wipe_step ? sweep_q : esum_q;
  assign res_wdata = cmd_i.wipe_step ? '0 : {1'b1, res_rd_q[PCOEF_W-1:0] + prod_q};
  assign res_re    = cmd_i.acc_read | cmd_i.pos_read | cmd_i.scan_read;

  always_comb begin
    if (cmd_i.acc_read) begin
      res_raddr = esum_q;
    end else if (cmd_i.pos_read) begin
      res_raddr = RA_W'(pos_q - RP_W'(1));
    end else begin
      res_raddr = scan_q - RA_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_we) begin
      res_mem[res_waddr] <= res_wdata;
    end
    if (res_re) begin
      res_rd_q <= res_mem[res_raddr];
    end
  end

  // Counts, overflow flag, pair indices, sweep and read pointers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_cnt_q  <= '0;
      second_cnt_q <= '0;
      overflow_q   <= 1'b0;
      i_q          <= '0;
      j_q          <= '0;
      sweep_q      <= '0;
      pos_q        <= '0;
      scan_q       <= '0;
    end else begin
      if (cmd_i.clr_regs) begin
        first_cnt_q  <= '0;
        second_cnt_q <= '0;
        overflow_q   <= 1'b0;
      end
      if (cmd_i.load_first && exp_ok) begin
        if (first_full) begin
          overflow_q <= 1'b1;
        end else begin
          first_cnt_q <= first_cnt_q + CNT_W'(1);
        end
      end
      if (cmd_i.load_second && exp_ok) begin
        if (second_full) begin
          overflow_q <= 1'b1;
        end else begin
          second_cnt_q <= second_cnt_q + CNT_W'(1);
        end
      end
      if (cmd_i.pair_start) begin
        i_q <= '0;
        j_q <= '0;
      end else if (cmd_i.pair_next) begin
        if (j_last) begin
          j_q <= '0;
          i_q <= i_q + IDX_W'(1);
        end else begin
          j_q <= j_q + IDX_W'(1);
        end
      end
      if (cmd_i.wipe_start) begin
        sweep_q <= '0;
      end else if (cmd_i.wipe_step) begin
        sweep_q <= sweep_q + RA_W'(1);
      end
      if (cmd_i.wipe_start) begin
        pos_q <= '0;
      end else if (cmd_i.pos_top) begin
        pos_q <= RP_W'(RES_DEPTH);
      end else if (cmd_i.pos_dec || cmd_i.hit_take) begin
        pos_q <= pos_q - RP_W'(1);
      end
      if (cmd_i.hit_take) begin
        scan_q <= RA_W'(pos_q - RP_W'(1));
      end else if (cmd_i.scan_dec) begin
        scan_q <= scan_q - RA_W'(1);
      end
    end
  end

  // Product and exponent sum of the current pair.
  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_capture) begin
      prod_q <= fc_rd_q * sc_rd_q;
      esum_q <= RA_W'(fe_rd_q) + RA_W'(se_rd_q);
    end
  end

  // Found term held until it can move to the output register.
  always_ff @(posedge clk_i) begin
    if (cmd_i.hit_empty) begin
      hit_sum_q   <= '0;
      hit_exp_q   <= '0;
      hit_last_q  <= 1'b0;
      hit_empty_q <= 1'b1;
    end else if (cmd_i.hit_take) begin
      hit_sum_q   <= res_rd_q[PCOEF_W-1:0];
      hit_exp_q   <= PEXP_W'(pos_q - RP_W'(1));
      hit_empty_q <= 1'b0;
    end
    if (cmd_i.set_last) begin
      hit_last_q <= 1'b1;
    end else if (cmd_i.clr_last) begin
      hit_last_q <= 1'b0;
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      product_coefficient_o <= hit_sum_q;
      product_exponent_o    <= hit_exp_q;
      last_term_o           <= hit_last_q;
      empty_res_o           <= hit_empty_q;
      overflow_o            <= overflow_q;
    end
  end

  assign out_valid_o = out_valid_q;

  // Status toward the controller.
  assign sts_o.wipe_last     = (sweep_q == RA_W'(RES_DEPTH - 1));
  assign sts_o.terms_present = (first_cnt_q != '0) && (second_cnt_q != '0);
  assign sts_o.pair_last     = i_last && j_last;
  assign sts_o.pos_zero      = (pos_q == '0);
  assign sts_o.scan_zero     = (scan_q == '0);
  assign sts_o.rd_present    = res_rd_q[PCOEF_W];
  assign sts_o.out_free      = !out_valid_q || out_ready_i;

endmodule

[hw/rtl/polynomial_multiplier_core.sv]
// Top level of the sparse polynomial multiplier.
//
// Commands arrive as words on the slave stream: the opcode travels in tuser,
// coefficient and exponent in tdata. Clear, load and compute produce no
// output; every read produces exactly one word on the master stream.
// A load is stored as it is accepted. Clear sweeps all 2*MAX_EXPONENT+1
// entries of the result store to zero, one entry at a time. Compute does
// that same sweep, then for each product pair a term read, a multiply, a
// result read and an accumulate write through the result store.
// A read scans the result store downward, reading and checking each entry:
// first to the next occupied exponent, then on below it to decide tlast.
// After reset the result store is swept once and s_axis_tready_o stays low
// until the sweep is done.
// The result leaves through an output register; while the receiver stalls
// it holds its word and the core keeps taking commands. Only a second read
// waits for the register to empty before finishing.
module polynomial_multiplier_core import pmul_pkg::*; #(
  parameter int MAX_TERMS    = 16,
  parameter int MAX_EXPONENT = 255
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid_i,
  output logic                 s_axis_tready_o,
  // coefficient[15:0], exponent[23:16]
  input  logic [S_TDATA_W-1:0] s_axis_tdata_i,
  // opcode[2:0]
  input  logic [OP_W-1:0]      s_axis_tuser_i,
  output logic                 m_axis_tvalid_o,
  input  logic                 m_axis_tready_i,
  // product_coefficient[31:0], product_exponent[40:32], overflow[41], zero fill
  output logic [M_TDATA_W-1:0] m_axis_tdata_o,
  // empty_res[0]
  output logic                 m_axis_tuser_o,
  // last_term
  output logic                 m_axis_tlast_o
);

  localparam int M_PAD_W = M_TDATA_W - (PCOEF_W + PEXP_W + 1);

  cmd_t               cmd;
  sts_t               sts;
  logic [PCOEF_W-1:0] product_coefficient;
  logic [PEXP_W-1:0]  product_exponent;
  logic               overflow;

  pmul_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .opcode_i   (s_axis_tuser_i),
    .in_ready_o (s_axis_tready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  pmul_dpath #(
    .MAX_TERMS    (MAX_TERMS),
    .MAX_EXPONENT (MAX_EXPONENT)
  ) u_dpath (
    .clk_i                 (clk_i),
    .rst_ni                (rst_ni),
    .cmd_i                 (cmd),
    .coefficient_i         (s_axis_tdata_i[COEF_W-1:0]),
    .exponent_i            (s_axis_tdata_i[COEF_W+EXP_W-1:COEF_W]),
    .out_ready_i           (m_axis_tready_i),
    .sts_o                 (sts),
    .out_valid_o           (m_axis_tvalid_o),
    .product_coefficient_o (product_coefficient),
    .product_exponent_o    (product_exponent),
    .last_term_o           (m_axis_tlast_o),
    .empty_res_o           (m_axis_tuser_o),
    .overflow_o            (overflow)
  );

  // Pack the output word.
  assign m_axis_tdata_o = {{M_PAD_W{1'b0}}, overflow, product_exponent, product_coefficient};

endmodule

[hw/rtl/pmul_checker.sv]
// Port-level assertions for the sparse polynomial multiplier and their binding.
module pmul_checker import pmul_pkg::*; (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 s_axis_tvalid_i,
  input logic                 s_axis_tready_i,
  input logic [OP_W-1:0]      s_axis_tuser_i,
  input logic                 m_axis_tvalid_i,
  input logic                 m_axis_tready_i,
  input logic [M_TDATA_W-1:0] m_axis_tdata_i,
  input logic                 m_axis_tuser_i,
  input logic                 m_axis_tlast_i
);

  logic s_acc;

  assign s_acc = s_axis_tvalid_i && s_axis_tready_i;

  // A stalled output word holds.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_i && !m_axis_tready_i |=> m_axis_tvalid_i &&
      $stable(m_axis_tdata_i) && $stable(m_axis_tuser_i) && $stable(m_axis_tlast_i))
    else $error("output word changed while stalled");

  // A read always needs at least one scan step before the next word.
  a_read_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_acc && s_axis_tuser_i == OP_READ |=> !s_axis_tready_i)
    else $error("input ready right after a read");

  // Clear and compute start a sweep of the result store.
  a_sweep_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_acc && (s_axis_tuser_i == OP_CLEAR || s_axis_tuser_i == OP_COMPUTE)
      |=> !s_axis_tready_i)
    else $error("input ready right after clear or compute");

  // Loads leave the input ready in the following cycle.
  a_load_fast: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_acc && (s_axis_tuser_i == OP_LOAD_FIRST || s_axis_tuser_i == OP_LOAD_SECOND)
      |=> s_axis_tready_i)
    else $error("input not ready after a load");

  // An empty answer carries no term.
  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_i && m_axis_tuser_i |->
      m_axis_tdata_i[PCOEF_W+PEXP_W-1:0] == '0 && !m_axis_tlast_i)
    else $error("empty answer with term data");

endmodule

bind polynomial_multiplier_core pmul_checker u_pmul_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_i (s_axis_tready_o),
  .s_axis_tuser_i  (s_axis_tuser_i),
  .m_axis_tvalid_i (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_i  (m_axis_tdata_o),
  .m_axis_tuser_i  (m_axis_tuser_o),
  .m_axis_tlast_i  (m_axis_tlast_o)
);

[dv/tb.sv]
// Self-checking stream testbench for the sparse polynomial multiplier core.
`timescale 1ns / 100ps

import pmul_pkg::*;

localparam int unsigned TERMS       = 16;
localparam int unsigned EXP_TOP     = 255;
localparam int unsigned SUM_SLOTS   = 2 * EXP_TOP + 1;
localparam int unsigned ITEM_TARGET = 1650;
localparam int unsigned CYCLE_LIMIT = 12_000_000;

// One result term as it leaves the master stream.
typedef struct packed {
  logic [PCOEF_W-1:0] coef;
  logic [PEXP_W-1:0]  expo;
  logic               last;
  logic               empty;
  logic               ovf;
} term_word_t;

// Tracks the term stores and the result store, and the terms still owed by reads.
class poly_product_board;
  logic signed [COEF_W-1:0] term_coef [2][TERMS];
  logic [EXP_W-1:0]         term_exp  [2][TERMS];
  int unsigned              term_cnt  [2];
  logic [PCOEF_W-1:0]       sum_at    [SUM_SLOTS];
  bit                       hit_at    [SUM_SLOTS];
  int unsigned              read_pos;
  bit                       ovf_flag;
  term_word_t               awaited[$];
  int unsigned              mismatches;

  function new();
    term_cnt[0] = 0;
    term_cnt[1] = 0;
    ovf_flag    = 1'b0;
    mismatches  = 0;
    wipe_sums();
  endfunction

  function void wipe_sums();
    foreach (sum_at[k]) begin
      sum_at[k] = '0;
      hit_at[k] = 1'b0;
    end
    read_pos = 0;
  endfunction

  function int unsigned pending();
    return awaited.size();
  endfunction

  // Result terms not yet read out.
  function int unsigned terms_waiting();
    int unsigned n;
    n = 0;
    for (int unsigned k = 0; k < read_pos; k++) begin
      if (hit_at[k]) n++;
    end
    return n;
  endfunction

  // Updates the prediction for one accepted command word.
  function void note_word(logic [OP_W-1:0] op, logic signed [COEF_W-1:0] coef,
                          logic [EXP_W-1:0] expo);
    int unsigned side;
    int unsigned e;
    int unsigned pos;
    logic signed [PCOEF_W-1:0] prod;
    term_word_t w;
    case (op)
      OP_CLEAR: begin
        term_cnt[0] = 0;
        term_cnt[1] = 0;
        ovf_flag    = 1'b0;
        wipe_sums();
      end
      OP_LOAD_FIRST, OP_LOAD_SECOND: begin
        side = (op == OP_LOAD_FIRST) ? 0 : 1;
        if (expo <= EXP_TOP) begin
          if (term_cnt[side] >= TERMS) begin
            ovf_flag = 1'b1;
          end else begin
            term_coef[side][term_cnt[side]] = coef;
            term_exp[side][term_cnt[side]]  = expo;
            term_cnt[side]++;
          end
        end
      end
      OP_COMPUTE: begin
        wipe_sums();
        for (int unsigned i = 0; i < term_cnt[0]; i++) begin
          for (int unsigned j = 0; j < term_cnt[1]; j++) begin
            e    = term_exp[0][i] + term_exp[1][j];
            prod = term_coef[0][i] * term_coef[1][j];
            if (e < SUM_SLOTS) begin
              sum_at[e] = sum_at[e] + prod;
              hit_at[e] = 1'b1;
            end
          end
        end
        read_pos = SUM_SLOTS;
      end
      OP_READ: begin
        pos = read_pos;
        while (pos > 0 && !hit_at[pos-1]) pos--;
        w     = '0;
        w.ovf = ovf_flag;
        if (pos == 0) begin
          read_pos = 0;
          w.empty  = 1'b1;
        end else begin
          read_pos = pos - 1;
          w.coef   = sum_at[read_pos];
          w.expo   = PEXP_W'(read_pos);
          w.last   = 1'b1;
          for (int unsigned b = 0; b < read_pos; b++) begin
            if (hit_at[b]) w.last = 1'b0;
          end
        end
        awaited.push_back(w);
      end
      default: ;
    endcase
  endfunction

  // Compares one accepted output word with the oldest outstanding read.
  function void check_word(logic [M_TDATA_W-1:0] data, logic user, logic lastb);
    term_word_t got;
    term_word_t want;
    got.coef  = data[PCOEF_W-1:0];
    got.expo  = data[PCOEF_W +: PEXP_W];
    got.ovf   = data[PCOEF_W + PEXP_W];
    got.empty = user;
    got.last  = lastb;
    if (awaited.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("[%0t] word with no read outstanding: coef %0d exp %0d last %b empty %b ovf %b",
                 $time, $signed(got.coef), got.expo, got.last, got.empty, got.ovf);
      return;
    end
    want = awaited.pop_front();
    if (got.coef !== want.coef || got.expo !== want.expo || got.last !== want.last ||
        got.empty !== want.empty || got.ovf !== want.ovf) begin
      mismatches++;
      if (mismatches <= 10)
        $display("[%0t] term mismatch: coef %0d/%0d exp %0d/%0d last %b/%b empty %b/%b ovf %b/%b %s",
                 $time, $signed(want.coef), $signed(got.coef), want.expo, got.expo,
                 want.last, got.last, want.empty, got.empty, want.ovf, got.ovf,
                 "(expected/actual)");
    end
  endfunction
endclass

module tb;

  logic                 clk_i   = 1'b0;
  logic                 rst_ni  = 1'b0;
  logic                 s_valid = 1'b0;
  logic [S_TDATA_W-1:0] s_data  = '0;
  logic [OP_W-1:0]      s_user  = '0;
  logic                 m_ready = 1'b1;
  wire                  s_ready;
  wire                  m_valid;
  wire [M_TDATA_W-1:0]  m_data;
  wire                  m_user;
  wire                  m_last;

  poly_product_board sb;
  bit                tx_idle_on   = 1'b0;
  bit                rx_idle_on   = 1'b0;
  int unsigned       hold_request = 0;
  int unsigned       stall_left   = 0;
  int unsigned       items_sent   = 0;
  int unsigned       cycle_count  = 0;

  // Clock: 10 ns period.
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  polynomial_multiplier_core #(
    .MAX_TERMS    (TERMS),
    .MAX_EXPONENT (EXP_TOP)
  ) u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_data),
    .s_axis_tuser_i  (s_user),
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_data),
    .m_axis_tuser_o  (m_user),
    .m_axis_tlast_o  (m_last)
  );

  // Result receiver: checks each word, then, with idling enabled, holds off ready for a random stall.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_ready && m_valid) begin
        sb.check_word(m_data, m_user, m_last);
        stall_left = rx_idle_on ? $urandom_range(0, 17) : 0;
      end else if (!m_ready && stall_left > 0) begin
        stall_left--;
      end
      if (hold_request > 0) begin
        stall_left   = hold_request;
        hold_request = 0;
      end
      m_ready <= (stall_left == 0);
    end
  end

  // Offers one command word after a random gap and waits until it is taken.
  task automatic send_word(input logic [OP_W-1:0] op, input logic signed [COEF_W-1:0] coef,
                           input logic [EXP_W-1:0] expo);
    int unsigned gap;
    gap = tx_idle_on ? $urandom_range(0, 17) : 0;
    if (gap > 0) begin
      s_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_valid <= 1'b1;
    s_user  <= op;
    s_data  <= {expo, coef};
    do @(posedge clk_i); while (!s_ready);
    sb.note_word(op, coef, expo);
    if (op <= OP_READ) items_sent++;
  endtask

  // Stops offering words until every outstanding read has been answered.
  task automatic drain_results();
    s_valid <= 1'b0;
    do @(posedge clk_i); while (sb.pending() != 0);
  endtask

  function automatic logic [COEF_W-1:0] rand_coef(bit extreme);
    if (extreme) return $urandom_range(0, 1) ? 16'h8000 : 16'h7FFF;
    return COEF_W'($urandom());
  endfunction

  function automatic logic [EXP_W-1:0] rand_exp(bit narrow);
    if (narrow) return $urandom_range(0, 1) ? EXP_W'($urandom_range(0, 3)) : EXP_W'(EXP_TOP);
    return EXP_W'($urandom());
  endfunction

  function automatic int unsigned rand_term_count();
    if ($urandom_range(0, 9) == 0) return $urandom_range(12, 20);
    return $urandom_range(0, 6);
  endfunction

  // Optional clear, interleaved loads with occasional unused opcodes, compute, then reads down the result.
  task automatic run_product_sequence();
    int unsigned n_first;
    int unsigned n_second;
    int unsigned reads;
    bit          extreme;
    bit          narrow;
    n_first  = rand_term_count();
    n_second = rand_term_count();
    extreme  = ($urandom_range(0, 3) == 0);
    narrow   = ($urandom_range(0, 2) == 0);
    if ($urandom_range(0, 2) != 0) send_word(OP_CLEAR, rand_coef(0), rand_exp(0));
    while (n_first + n_second > 0) begin
      if (n_first > 0 && (n_second == 0 || $urandom_range(0, 1))) begin
        send_word(OP_LOAD_FIRST, rand_coef(extreme), rand_exp(narrow));
        n_first--;
      end else begin
        send_word(OP_LOAD_SECOND, rand_coef(extreme), rand_exp(narrow));
        n_second--;
      end
      if ($urandom_range(0, 15) == 0)
        send_word(OP_W'($urandom_range(OP_READ + 1, 7)), rand_coef(0), rand_exp(0));
    end
    send_word(OP_COMPUTE, rand_coef(0), rand_exp(0));
    reads = sb.terms_waiting();
    if ($urandom_range(0, 4) == 0) reads = reads / 2;
    else reads += $urandom_range(0, 2);
    repeat (reads) send_word(OP_READ, rand_coef(0), rand_exp(0));
  endtask

  // Arbitrary words, unused opcodes included.
  task automatic run_noise();
    repeat ($urandom_range(4, 16))
      send_word(OP_W'($urandom_range(0, 7)), rand_coef(0), rand_exp(0));
  endtask

  // Watchdog on the total run length.
  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("Verification failed");
    $finish;
  end

  initial begin : stimulus
    sb = new();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: empty reads, extreme terms, repeated exponents, unused opcodes, a zero sum.
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
    send_word(OP_READ, 16'h0000, 8'h00);
    send_word(OP_COMPUTE, 16'hFFFF, 8'hFF);
    send_word(OP_READ, 16'hFFFF, 8'hFF);
    send_word(OP_LOAD_FIRST, 16'h8000, 8'd255);
    send_word(OP_LOAD_FIRST, 16'h7FFF, 8'd0);
    send_word(OP_LOAD_FIRST, 16'h0001, 8'd5);
    send_word(OP_LOAD_SECOND, 16'h8000, 8'd255);
    send_word(OP_LOAD_SECOND, 16'hFFFF, 8'd0);
    send_word(OP_LOAD_SECOND, 16'h0001, 8'd5);
    send_word(OP_LOAD_SECOND, 16'hFFFF, 8'd5);
    for (int k = OP_READ + 1; k < (1 << OP_W); k++) send_word(OP_W'(k), 16'h5A5A, 8'hA5);
    send_word(OP_COMPUTE, 16'h0000, 8'h00);
    repeat (7) send_word(OP_READ, 16'h0000, 8'h00);
    send_word(OP_CLEAR, 16'hA5A5, 8'h5A);

    // Back pressure: the receiver holds off while reads pile up at the input.
    tx_idle_on = 1'b0;
    for (int k = 0; k < 4; k++) begin
      send_word(OP_LOAD_FIRST, rand_coef(0), EXP_W'(k * 9));
      send_word(OP_LOAD_SECOND, rand_coef(0), EXP_W'(k * 40));
    end
    send_word(OP_COMPUTE, 16'h0000, 8'h00);
    hold_request = 2500;
    repeat (12) send_word(OP_READ, rand_coef(0), rand_exp(0));
    drain_results();

    // Random sequences, mostly well formed.
    while (items_sent < ITEM_TARGET) begin
      tx_idle_on = ($urandom_range(0, 3) != 0);
      rx_idle_on = ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 4) == 0) run_noise();
      else run_product_sequence();
      if ($urandom_range(0, 5) == 0) drain_results();
    end

    drain_results();
    repeat (2500) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
